// ----- rtl/sirc_ir_pulse_decoder_top_defines.svh -----
// Assertion macros for the SIRC decoder checker.
// No dependencies; included by the assertion checker file.
`ifndef SIRC_IR_PULSE_DECODER_TOP_DEFINES_SVH
`define SIRC_IR_PULSE_DECODER_TOP_DEFINES_SVH

// Checked only outside reset.
`define SIRC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define SIRC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- rtl/sirc_pkg.sv -----
// Shared types and constants for the SIRC infrared pulse decoder.
// No dependencies; used by sirc_match, sirc_ir_pulse_decoder_top and sirc_chk.
package sirc_pkg;

    // Bounds are nominal/100 * (100 +- tol); all nominals are whole hundreds.
    localparam int unsigned BOUND_W        = 13;  // 24 * 227 = 5448 max
    localparam int unsigned TOL_W          = 7;
    localparam int unsigned TOL_RESET      = 25;
    localparam int unsigned PCT_FULL       = 100;
    localparam int unsigned HDR_MARK_UNIT  = 24;  // 2400 us
    localparam int unsigned ONE_MARK_UNIT  = 12;  // 1200 us
    localparam int unsigned SHORT_UNIT     = 6;   // 600 us: header space, zero mark, bit space

    localparam int unsigned DATA_W         = 20;
    localparam int unsigned COUNT_W        = 5;
    localparam int unsigned MAX_BITS       = 20;
    localparam int unsigned SHORT_FRAME    = 12;
    localparam int unsigned MID_FRAME      = 15;
    localparam int unsigned OUT_TDATA_W    = 32;

    localparam int unsigned APB_ADDR_W     = 3;
    localparam int unsigned APB_DATA_W     = 32;

    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_REJECT = 1'b1;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'b0001,
        PH_HDR_SPACE = 4'b0010,
        PH_BIT_MARK  = 4'b0100,
        PH_BIT_SPACE = 4'b1000
    } t_phase;

    // Duration classification of one pulse against the current tolerance.
    typedef struct packed {
        logic hdr_mark;    // fits 2400
        logic one_mark;    // fits 1200
        logic short_pulse; // fits 600
        logic long_space;  // above upper bound of 600
    } t_match;

endpackage

// ----- rtl/sirc_match.sv -----
// Duration matcher: tolerance window bounds and pulse classification.
// Depends on sirc_pkg.
module sirc_match #(
    parameter int unsigned DURATION_BITS = 16
) (
    input  logic [sirc_pkg::TOL_W-1:0] i_tol,
    input  logic [DURATION_BITS-1:0]   i_dur,
    output sirc_pkg::t_match           o_match
);

    localparam int unsigned BW = sirc_pkg::BOUND_W;
    localparam int unsigned CW = (DURATION_BITS > BW) ? DURATION_BITS : BW;

    logic [BW-1:0] lo_base, hi_base;
    logic [BW-1:0] lo_hdr, hi_hdr, lo_one, hi_one, lo_short, hi_short;
    logic [CW-1:0] d;

    // lower base clamps at zero once tolerance reaches 100 %
    assign lo_base = (i_tol >= sirc_pkg::TOL_W'(sirc_pkg::PCT_FULL)) ? '0 :
                     BW'(sirc_pkg::PCT_FULL) - BW'(i_tol);
    assign hi_base = BW'(sirc_pkg::PCT_FULL) + BW'(i_tol);

    assign lo_hdr   = lo_base * BW'(sirc_pkg::HDR_MARK_UNIT);
    assign hi_hdr   = hi_base * BW'(sirc_pkg::HDR_MARK_UNIT);
    assign lo_one   = lo_base * BW'(sirc_pkg::ONE_MARK_UNIT);
    assign hi_one   = hi_base * BW'(sirc_pkg::ONE_MARK_UNIT);
    assign lo_short = lo_base * BW'(sirc_pkg::SHORT_UNIT);
    assign hi_short = hi_base * BW'(sirc_pkg::SHORT_UNIT);

    assign d = CW'(i_dur);

    assign o_match.hdr_mark    = (d >= CW'(lo_hdr))   && (d <= CW'(hi_hdr));
    assign o_match.one_mark    = (d >= CW'(lo_one))   && (d <= CW'(hi_one));
    assign o_match.short_pulse = (d >= CW'(lo_short)) && (d <= CW'(hi_short));
    assign o_match.long_space  = d > CW'(hi_short);

endmodule

// ----- rtl/sirc_ir_pulse_decoder_top.sv -----
// SIRC infrared pulse decoder, top level.
// Depends on sirc_pkg and sirc_match.
//
// Usage:
//  - Slave stream: one beat per IR pulse. tuser = is_mark (1 mark, 0 space),
//    tdata = pulse length in us (DURATION_BITS, zero padded to bytes).
//  - Master stream: one beat per finished or rejected frame. tuser = status
//    (0 decoded, 1 rejected), tdata = {pad, bit_count[4:0], frame_data[19:0]}.
//    frame_data holds the received bits, first bit most significant.
//  - APB port: one register, tolerance_percent at byte address 0 (7 bits,
//    reset 25). Write it only while no pulse is in flight.
//  - Pipeline: input register, then classification and frame state update
//    into an output register that holds the result beat.
//  - Throughput: one pulse per cycle while no result beat waits on
//    i_m_tready low; most pulses give no result beat.
//  - Stall: while a result beat waits on i_m_tready low, the pulse held in
//    the input register waits too, and o_s_tready drops once that register
//    is full. Nothing is dropped.
//  - Reset (synchronous, active low): decoder idle waiting for a header
//    mark, both registers empty, tolerance back to 25 %.
module sirc_ir_pulse_decoder_top #(
    parameter int unsigned DURATION_BITS = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    // pulse input
    input  logic                                     i_s_tvalid,
    output logic                                     o_s_tready,
    input  logic [((DURATION_BITS+7)/8)*8-1:0]       i_s_tdata,  // duration_us
    input  logic                                     i_s_tuser,  // is_mark
    // frame output
    output logic                                     o_m_tvalid,
    input  logic                                     i_m_tready,
    output logic [sirc_pkg::OUT_TDATA_W-1:0]         o_m_tdata,  // frame_data, bit_count
    output logic                                     o_m_tuser,  // status
    // configuration
    input  logic                                     i_psel,
    input  logic                                     i_penable,
    input  logic                                     i_pwrite,
    input  logic [sirc_pkg::APB_ADDR_W-1:0]          i_paddr,
    input  logic [sirc_pkg::APB_DATA_W-1:0]          i_pwdata,
    output logic [sirc_pkg::APB_DATA_W-1:0]          o_prdata,
    output logic                                     o_pready
);

    localparam int unsigned DW = sirc_pkg::DATA_W;
    localparam int unsigned NW = sirc_pkg::COUNT_W;

    // config register
    logic [sirc_pkg::TOL_W-1:0] r_tol;
    logic                       reg_sel;

    // input stage
    logic                     r_v1;
    logic                     r_mark1;
    logic [DURATION_BITS-1:0] r_dur1;

    // frame state
    sirc_pkg::t_phase r_phase, n_phase;
    logic [DW-1:0]    r_shift, n_shift;
    logic [NW-1:0]    r_bits,  n_bits;

    // output stage
    logic          r_ov;
    logic          r_ostat;
    logic [DW-1:0] r_odata;
    logic [NW-1:0] r_ocnt;

    logic            advance;
    logic            s_beat;
    logic            emit;
    logic            emit_stat;
    sirc_pkg::t_match m;
    logic            cnt_ok;
    logic            cnt_ok_short;
    logic            bit_val;

    // APB: word 0 is the tolerance; only paddr[2] selects the word
    assign reg_sel  = (i_paddr[2] == 1'b0);
    assign o_pready = 1'b1;
    assign o_prdata = reg_sel ? sirc_pkg::APB_DATA_W'(r_tol) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= sirc_pkg::TOL_W'(sirc_pkg::TOL_RESET);
        end else if (i_psel && i_penable && i_pwrite && reg_sel) begin
            r_tol <= i_pwdata[sirc_pkg::TOL_W-1:0];
        end
    end

    // handshakes: the pipe moves whenever the output slot is free or draining
    assign advance    = !r_ov || i_m_tready;
    assign o_s_tready = !r_v1 || advance;
    assign s_beat     = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (s_beat) begin
            r_v1 <= 1'b1;
        end else if (advance) begin
            r_v1 <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_beat) begin
            r_mark1 <= i_s_tuser;
            r_dur1  <= i_s_tdata[DURATION_BITS-1:0];
        end
    end

    sirc_match #(
        .DURATION_BITS(DURATION_BITS)
    ) u_match (
        .i_tol  (r_tol),
        .i_dur  (r_dur1),
        .o_match(m)
    );

    assign cnt_ok_short = (r_bits == NW'(sirc_pkg::SHORT_FRAME)) ||
                          (r_bits == NW'(sirc_pkg::MID_FRAME));
    assign cnt_ok       = cnt_ok_short || (r_bits == NW'(sirc_pkg::MAX_BITS));
    // one-mark wins when both windows overlap
    assign bit_val      = m.one_mark;

    always_comb begin
        n_phase   = r_phase;
        n_shift   = r_shift;
        n_bits    = r_bits;
        emit      = 1'b0;
        emit_stat = sirc_pkg::STATUS_OK;
        unique case (r_phase)
            sirc_pkg::PH_IDLE: begin
                if (r_mark1 && m.hdr_mark) begin
                    n_phase = sirc_pkg::PH_HDR_SPACE;
                end
            end
            sirc_pkg::PH_HDR_SPACE: begin
                if (!r_mark1 && m.short_pulse) begin
                    n_phase = sirc_pkg::PH_BIT_MARK;
                    n_shift = '0;
                    n_bits  = '0;
                end else if (r_mark1 && m.hdr_mark) begin
                    n_phase = sirc_pkg::PH_HDR_SPACE;  // header restarts
                end else begin
                    n_phase = sirc_pkg::PH_IDLE;
                end
            end
            sirc_pkg::PH_BIT_MARK: begin
                if (r_mark1 && (m.one_mark || m.short_pulse)) begin
                    n_shift = {r_shift[DW-2:0], bit_val};
                    n_bits  = r_bits + NW'(1);
                    n_phase = sirc_pkg::PH_BIT_SPACE;
                end else begin
                    // unmatched pulse: short frames end here
                    emit      = 1'b1;
                    emit_stat = cnt_ok_short ? sirc_pkg::STATUS_OK
                                             : sirc_pkg::STATUS_REJECT;
                end
            end
            sirc_pkg::PH_BIT_SPACE: begin
                if (!r_mark1 && m.short_pulse) begin
                    if (r_bits >= NW'(sirc_pkg::MAX_BITS)) begin
                        emit = 1'b1;
                    end else begin
                        n_phase = sirc_pkg::PH_BIT_MARK;
                    end
                end else if (!r_mark1 && m.long_space) begin
                    emit      = 1'b1;
                    emit_stat = cnt_ok ? sirc_pkg::STATUS_OK : sirc_pkg::STATUS_REJECT;
                end else begin
                    emit      = 1'b1;
                    emit_stat = sirc_pkg::STATUS_REJECT;
                end
            end
            default: begin
                n_phase = sirc_pkg::PH_IDLE;
            end
        endcase
        if (emit) begin
            n_phase = sirc_pkg::PH_IDLE;
            n_shift = '0;
            n_bits  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= sirc_pkg::PH_IDLE;
            r_shift <= '0;
            r_bits  <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (r_v1 && advance) begin
                r_phase <= n_phase;
                r_shift <= n_shift;
                r_bits  <= n_bits;
            end
            if (r_v1 && advance && emit) begin
                r_ov <= 1'b1;
            end else if (i_m_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // result payload: partial or full frame as it stood before the ending pulse
    always_ff @(posedge i_clk) begin
        if (r_v1 && advance && emit) begin
            r_ostat <= emit_stat;
            r_odata <= r_shift;
            r_ocnt  <= r_bits;
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tuser  = r_ostat;
    assign o_m_tdata  = {{(sirc_pkg::OUT_TDATA_W-DW-NW){1'b0}}, r_ocnt, r_odata};

endmodule

// ----- rtl/sirc_chk.sv -----
// Port-level checker for the SIRC decoder, bound to the top level.
// Depends on sirc_pkg and sirc_ir_pulse_decoder_top_defines.svh.
`include "sirc_ir_pulse_decoder_top_defines.svh"

module sirc_chk (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_m_tvalid,
    input logic                               i_m_tready,
    input logic [sirc_pkg::OUT_TDATA_W-1:0]   o_m_tdata,
    input logic                               o_m_tuser
);

    logic [sirc_pkg::COUNT_W-1:0] cnt;
    assign cnt = o_m_tdata[sirc_pkg::DATA_W+sirc_pkg::COUNT_W-1:sirc_pkg::DATA_W];

    `SIRC_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_m_tvalid, "result valid right after reset")
    `SIRC_ASSERT(a_hold_valid, o_m_tvalid && !i_m_tready |=> o_m_tvalid, "stalled result dropped")
    `SIRC_ASSERT(a_hold_data, o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata) && $stable(o_m_tuser), "stalled result changed")
    `SIRC_ASSERT(a_ok_count, o_m_tvalid && (o_m_tuser == sirc_pkg::STATUS_OK) |-> (cnt == 5'd12) || (cnt == 5'd15) || (cnt == 5'd20), "decoded frame with bad bit count")
    `SIRC_ASSERT(a_count_max, o_m_tvalid |-> cnt <= 5'd20, "bit count above 20")

endmodule

bind sirc_ir_pulse_decoder_top sirc_chk u_sirc_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .o_m_tvalid(o_m_tvalid),
    .i_m_tready(i_m_tready),
    .o_m_tdata (o_m_tdata),
    .o_m_tuser (o_m_tuser)
);
